>>> hdl/ulr_pkg.sv
package ulr_pkg;

  localparam int LOG_DEPTH_DEF = 32;

  localparam logic [2:0] KIND_WRITE   = 3'd1;
  localparam logic [2:0] KIND_BEGIN   = 3'd2;
  localparam logic [2:0] KIND_RECOVER = 3'd5;

  localparam logic [1:0] OUT_STATUS  = 2'd0;
  localparam logic [1:0] OUT_RESTORE = 2'd1;
  localparam logic [1:0] OUT_DONE    = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [2:0]  entry_type;
    logic [15:0] tx_id;
    logic [7:0]  resource_id;
    logic [31:0] prior_value;
    logic [31:0] new_value;
    logic [31:0] timestamp;
  } ulr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        overflow;
    logic [7:0]  restore_resource;
    logic [31:0] restore_value;
    logic [31:0] restore_time;
    logic [5:0]  restored_count;
    logic        last;
  } ulr_out_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] tx;
    logic [7:0]  resource;
    logic [31:0] value;
  } ulr_entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_DONE
  } ulr_state_t;

endpackage

>>> hdl/ulr_log_mem.sv
module ulr_log_mem
  import ulr_pkg::*;
#(
  parameter int DEPTH = LOG_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  ulr_entry_t               wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output ulr_entry_t               rd_data
);

  ulr_entry_t mem [DEPTH];
  ulr_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/undo_log_rollback_engine.sv
// Channel  Direction  Ports                          Moves
// in       input      in_valid, in_stall, in_data    append or rollback request
// out      output     out_valid, out_stall, out_data status, restore or done item
//
// An append request is taken every cycle while the output register can drain
// and the engine is idle. A rollback scans back from the newest entry: S_READ
// reads the single log memory read port and S_EVAL examines the registered data.
// Reset (rst_n low, synchronous) clears the fill count, the scan state and
// the output valid; log contents are not cleared. out_stall holds the output
// register and, through it, stalls new requests and scan steps that emit items.
module undo_log_rollback_engine
  import ulr_pkg::*;
#(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ulr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output ulr_out_t out_data
);

  localparam int ADDR_W = $clog2(LOG_DEPTH);
  localparam int FILL_W = $clog2(LOG_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LOG_DEPTH);

  ulr_state_t        state_r, state_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] idx_r, idx_nxt;
  logic [15:0]       tx_r, tx_nxt;
  logic [31:0]       time_r, time_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  ulr_out_t          out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              out_free;
  logic              has_room;
  logic [FILL_W-1:0] idx_m1;
  logic              in_stall_c;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  ulr_entry_t        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  ulr_entry_t        rd_data;

  ulr_log_mem #(
    .DEPTH(LOG_DEPTH)
  ) u_log_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign has_room = (fill_r < FILL_MAX);
  assign idx_m1   = idx_r - FILL_W'(1);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    tx_nxt        = tx_r;
    time_nxt      = time_r;
    cnt_nxt       = cnt_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    in_stall_c    = 1'b1;
    rd_en         = 1'b0;
    rd_addr       = idx_m1[ADDR_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = fill_r[ADDR_W-1:0];
    wr_data       = '0;
    case (state_r)
      S_IDLE: begin
        in_stall_c = !out_free;
        if (in_valid && out_free) begin
          if (!in_data.mode) begin
            wr_en            = has_room;
            wr_data.kind     = in_data.entry_type;
            wr_data.tx       = in_data.tx_id;
            wr_data.resource = in_data.resource_id;
            wr_data.value    = in_data.prior_value;
            if (has_room) begin
              fill_nxt = fill_r + FILL_W'(1);
            end
            out_nxt          = '0;
            out_nxt.kind     = OUT_STATUS;
            out_nxt.overflow = !has_room;
            out_nxt.last     = 1'b1;
            out_valid_nxt    = 1'b1;
          end else begin
            idx_nxt   = fill_r;
            tx_nxt    = in_data.tx_id;
            time_nxt  = in_data.timestamp;
            cnt_nxt   = '0;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        if (idx_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          rd_en     = 1'b1;
          idx_nxt   = idx_m1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (rd_data.tx != tx_r) begin
          state_nxt = S_READ;
        end else if (rd_data.kind == KIND_BEGIN) begin
          state_nxt = S_DONE;
        end else if (rd_data.kind == KIND_WRITE) begin
          if (out_free) begin
            wr_en            = has_room;
            wr_data.kind     = KIND_RECOVER;
            wr_data.tx       = tx_r;
            wr_data.resource = rd_data.resource;
            wr_data.value    = '0;
            if (has_room) begin
              fill_nxt = fill_r + FILL_W'(1);
            end
            out_nxt                  = '0;
            out_nxt.kind             = OUT_RESTORE;
            out_nxt.overflow         = !has_room;
            out_nxt.restore_resource = rd_data.resource;
            out_nxt.restore_value    = rd_data.value;
            out_nxt.restore_time     = time_r;
            out_valid_nxt            = 1'b1;
            cnt_nxt                  = cnt_r + 6'd1;
            time_nxt                 = time_r + 32'd1;
            state_nxt                = S_READ;
          end
        end else begin
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_nxt                = '0;
          out_nxt.kind           = OUT_DONE;
          out_nxt.restored_count = cnt_r;
          out_nxt.last           = 1'b1;
          out_valid_nxt          = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tx_r   <= tx_nxt;
    time_r <= time_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = in_stall_c;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count past log depth");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> (state_r == S_IDLE))
    else $error("request taken during a scan");

  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.mode) |=> (state_r == S_READ && cnt_r == '0))
    else $error("rollback did not start a clean scan");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (idx_r <= fill_r))
    else $error("scan index above fill count");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == OUT_RESTORE) |-> !out_data.last)
    else $error("restore item marked last");

endmodule
